FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BPCS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpcs assertion failed");

// Next-cycle implication.
`define BPCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpcs assertion failed");

`endif

FILE: src/bpcs_pkg.sv
// ----------------------------------------------------------------------------
// bpcs_pkg
// Types, register codes and helper functions of the bit-packed column scan.
// ----------------------------------------------------------------------------
package bpcs_pkg;

  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned WidthW     = 5;
  localparam int unsigned ValueW     = 31;
  localparam int unsigned BoundW     = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned DataW      = 32;
  localparam int unsigned InWordW    = 64;
  localparam int unsigned ResidueW   = 30;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ENTRY_WIDTH  = 3'd0,
    CFG_COMPARE_MODE = 3'd1,
    CFG_LOW_BOUND    = 3'd2,
    CFG_HIGH_BOUND   = 3'd3,
    CFG_ENTRY_COUNT  = 3'd4
  } cfg_index_e;

  typedef enum logic {
    MODE_EQUAL = 1'b0,
    MODE_RANGE = 1'b1
  } compare_mode_e;

  typedef struct packed {
    logic [WidthW-1:0] entry_width;
    logic              compare_mode;
    logic [BoundW-1:0] low_bound;
    logic [BoundW-1:0] high_bound;
    logic [CountW-1:0] entry_count;
  } bpcs_cfg_t;

  typedef struct packed {
    logic              match;
    logic [ValueW-1:0] entry_value;
    logic              last_in_word;
    logic              final_entry;
  } bpcs_result_t;

  // A width of zero behaves as one.
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
    eff_width = (w == '0) ? WidthW'(1) : w;
  endfunction

  function automatic logic [ValueW-1:0] width_mask(input logic [WidthW-1:0] w);
    width_mask = (ValueW'(1) << w) - ValueW'(1);
  endfunction

  function automatic logic entry_matches(input logic              mode,
                                         input logic [ValueW-1:0] value,
                                         input logic [BoundW-1:0] low,
                                         input logic [BoundW-1:0] high);
    logic signed [BoundW-1:0] sv;
    sv = $signed({1'b0, value});
    if (mode == MODE_RANGE) begin
      entry_matches = (sv >= $signed(low)) && (sv <= $signed(high));
    end else begin
      entry_matches = ({1'b0, value} == low);
    end
  endfunction

endpackage

FILE: src/bpcs_front.sv
// ----------------------------------------------------------------------------
// bpcs_front
// Input side: accepts packed words, drops bits above the word size and
// queues them for the unpack engine.
// ----------------------------------------------------------------------------
module bpcs_front #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bpcs_pkg::InWordW-1:0] packed_word_i,
  output logic                         word_valid_o,
  input  logic                         word_ready_i,
  output logic [WORD_BITS-1:0]         word_o
);

  localparam int unsigned PtrW  = bpcs_pkg::QueuePtrW;
  localparam int unsigned FillW = PtrW + 1;

  logic [WORD_BITS-1:0] mem_q [bpcs_pkg::QueueDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic                 push, pop;

  assign in_ready_o   = (fill_q != FillW'(bpcs_pkg::QueueDepth));
  assign word_valid_o = (fill_q != '0);
  assign word_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = word_valid_o && word_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Keep only the low WORD_BITS bits of the word.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= packed_word_i[WORD_BITS-1:0];
    end
  end

endmodule

FILE: src/bpcs_back.sv
// ----------------------------------------------------------------------------
// bpcs_back
// Unpack engine: joins residue and word in a shift buffer and, unless
// stalled, peels one entry per cycle, tests it and registers the result.
// ----------------------------------------------------------------------------
module bpcs_back #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bpcs_pkg::bpcs_cfg_t         cfg_i,
  input  logic                        clear_i,
  input  logic                        word_valid_i,
  output logic                        word_ready_o,
  input  logic [WORD_BITS-1:0]        word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bpcs_pkg::bpcs_result_t      result_o
);

  localparam int unsigned BufW   = WORD_BITS + bpcs_pkg::ResidueW;
  localparam int unsigned AvailW = $clog2(BufW + 1);
  localparam int unsigned CountW = bpcs_pkg::CountW;

  logic [BufW-1:0]              buf_q, buf_d;
  logic [AvailW-1:0]            avail_q, avail_d;
  logic                         busy_q, busy_d;
  logic [CountW-1:0]            done_q, done_d;
  logic                         out_valid_q, out_valid_d;
  bpcs_pkg::bpcs_result_t       result_q, result_d;

  logic [bpcs_pkg::WidthW-1:0]  w;
  logic [AvailW-1:0]            w_ext;
  logic [AvailW-1:0]            left;
  logic [BufW-1:0]              shifted;
  logic [CountW-1:0]            done_next;
  logic [bpcs_pkg::ValueW-1:0]  value;
  logic                         emit, is_final, is_last, done_now, load, scan_over;
  logic [BufW-1:0]              res_buf;
  logic [AvailW-1:0]            res_cnt;
  logic [CountW-1:0]            res_done;

  assign w         = bpcs_pkg::eff_width(cfg_i.entry_width);
  assign w_ext     = AvailW'(w);
  assign emit      = busy_q && (!out_valid_q || out_ready_i);
  assign done_next = done_q + CountW'(1);
  assign is_final  = (done_next == cfg_i.entry_count);
  assign left      = avail_q - w_ext;
  assign is_last   = (left < w_ext) || is_final;
  assign done_now  = emit && is_last;
  assign shifted   = buf_q >> w;
  assign value     = buf_q[bpcs_pkg::ValueW-1:0] & bpcs_pkg::width_mask(w);

  // Residue as seen by the next word, after the entry leaving now is taken out.
  always_comb begin
    if (done_now) begin
      res_buf  = is_final ? '0 : shifted;
      res_cnt  = is_final ? '0 : left;
      res_done = done_next;
    end else begin
      res_buf  = buf_q;
      res_cnt  = avail_q;
      res_done = done_q;
    end
  end

  assign word_ready_o = !busy_q || done_now;
  assign load         = word_valid_i && word_ready_o;
  assign scan_over    = (res_done >= cfg_i.entry_count);

  always_comb begin
    buf_d   = buf_q;
    avail_d = avail_q;
    busy_d  = busy_q;
    done_d  = done_q;
    if (emit) begin
      buf_d   = shifted;
      avail_d = left;
      done_d  = done_next;
      if (is_last) begin
        buf_d   = res_buf;
        avail_d = res_cnt;
        busy_d  = 1'b0;
      end
    end
    if (load) begin
      if (scan_over) begin
        // Scan finished: drop the word and the residue.
        buf_d   = '0;
        avail_d = '0;
        busy_d  = 1'b0;
      end else begin
        buf_d   = res_buf | (BufW'(word_i) << res_cnt);
        avail_d = res_cnt + AvailW'(WORD_BITS);
        busy_d  = 1'b1;
      end
    end
    if (clear_i) begin
      buf_d   = '0;
      avail_d = '0;
      busy_d  = 1'b0;
      done_d  = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (emit) begin
      out_valid_d           = 1'b1;
      result_d.match        = bpcs_pkg::entry_matches(cfg_i.compare_mode, value,
                                                      cfg_i.low_bound, cfg_i.high_bound);
      result_d.entry_value  = value;
      result_d.last_in_word = is_last;
      result_d.final_entry  = is_final;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      avail_q     <= '0;
      busy_q      <= 1'b0;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      avail_q     <= avail_d;
      busy_q      <= busy_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: src/bitpacked_column_scan.sv
// ----------------------------------------------------------------------------
// bitpacked_column_scan
// Unpacks a column of bit-packed unsigned entries and tests each against
// an equality or inclusive range predicate.
// ----------------------------------------------------------------------------
// Channels: the input channel takes one packed word per transfer, bit 0
// first; entries run on across word boundaries. The output channel gives
// one transfer per entry with the predicate bit, the entry value, a mark on
// the last entry completed by its word and a mark on entry entry_count.
// The config channel writes the five registers by index; writing the entry
// width or the entry count restarts the scan. Write config only when idle.
// A word goes from the queue into the shift buffer of the unpack engine,
// and each entry peeled from it is held in the result register. The shift
// buffer yields one entry per cycle while the output is not stalled; words
// after the end of the scan are dropped and give nothing. A two-word queue
// sits in front.
// Reset: registers return to width 1, equality mode, bounds and count 0;
// residue and entry counter clear. When the receiver stalls, the result
// register holds, the engine halts and the queue keeps taking words until
// it is full.
module bitpacked_column_scan #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bpcs_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [bpcs_pkg::DataW-1:0]       cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bpcs_pkg::InWordW-1:0]     packed_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             match_o,
  output logic [bpcs_pkg::ValueW-1:0]      entry_value_o,
  output logic                             last_in_word_o,
  output logic                             final_entry_o
);

  bpcs_pkg::bpcs_cfg_t    cfg_q, cfg_d;
  bpcs_pkg::bpcs_result_t result;
  logic                   cfg_write, clear;
  logic                   word_valid, word_ready;
  logic [WORD_BITS-1:0]   word;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    clear = 1'b0;
    if (cfg_write) begin
      case (cfg_index_i)
        bpcs_pkg::CFG_ENTRY_WIDTH: begin
          cfg_d.entry_width = cfg_data_i[bpcs_pkg::WidthW-1:0];
          clear             = 1'b1;
        end
        bpcs_pkg::CFG_COMPARE_MODE: begin
          cfg_d.compare_mode = cfg_data_i[0];
        end
        bpcs_pkg::CFG_LOW_BOUND: begin
          cfg_d.low_bound = cfg_data_i;
        end
        bpcs_pkg::CFG_HIGH_BOUND: begin
          cfg_d.high_bound = cfg_data_i;
        end
        bpcs_pkg::CFG_ENTRY_COUNT: begin
          cfg_d.entry_count = cfg_data_i;
          clear             = 1'b1;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_width  <= bpcs_pkg::WidthW'(1);
      cfg_q.compare_mode <= bpcs_pkg::MODE_EQUAL;
      cfg_q.low_bound    <= '0;
      cfg_q.high_bound   <= '0;
      cfg_q.entry_count  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bpcs_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .packed_word_i(packed_word_i),
    .word_valid_o (word_valid),
    .word_ready_i (word_ready),
    .word_o       (word)
  );

  bpcs_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_i     (clear),
    .word_valid_i(word_valid),
    .word_ready_o(word_ready),
    .word_i      (word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign match_o        = result.match;
  assign entry_value_o  = result.entry_value;
  assign last_in_word_o = result.last_in_word;
  assign final_entry_o  = result.final_entry;

endmodule

FILE: src/bpcs_checker.sv
// ----------------------------------------------------------------------------
// bpcs_checker
// Port-level checks of the column scan, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bpcs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        match_o,
  input logic [bpcs_pkg::ValueW-1:0] entry_value_o,
  input logic                        last_in_word_o,
  input logic                        final_entry_o
);

  logic [bpcs_pkg::ValueW+2:0] out_payload;

  assign out_payload = {match_o, entry_value_o, last_in_word_o, final_entry_o};

  // Hold a stalled result.
  `BPCS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_payload))

  // The end of the scan also ends the word that completed it.
  `BPCS_ASSERT_IMP(a_final_is_last, out_valid_o && final_entry_o, last_in_word_o)

  // Nothing follows the final entry right away.
  `BPCS_ASSERT_NEXT(a_final_drains, out_valid_o && out_ready_i && final_entry_o, !out_valid_o)

endmodule

bind bitpacked_column_scan bpcs_checker u_bpcs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .match_o       (match_o),
  .entry_value_o (entry_value_o),
  .last_in_word_o(last_in_word_o),
  .final_entry_o (final_entry_o)
);
